// File: rtl/core/sdp_pkg.sv
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared types and constants for the steering differential PWM block.
// ----------------------------------------------------------------------------
package sdp_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned DUTY_W   = 7;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned ZONE_W   = 3;

    localparam logic [COUNT_W-1:0] PERIOD_RESET = 7'd100;

    // Register byte addresses on the configuration port
    localparam logic [2:0] ADDR_PWM_PERIOD = 3'd0;

    // x / 10 == (x * 205) >> 11 for every 10-bit x
    localparam logic [7:0] OUTER_MULT  = 8'd205;
    localparam int unsigned OUTER_SHIFT = 11;

    // n / 100 == (n * 5243) >> 19 for n up to 1023 * 9
    localparam int unsigned INNER_SHIFT = 19;
    localparam int unsigned MULT_W      = 16;

    // Side and duty values handed from the duty calculator to the top level
    typedef struct packed {
        logic              steer_right;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
    } duty_result_t;

    // Combined constant (10 - reduction) * 5243 for each angle zone
    function automatic logic [MULT_W-1:0] inner_mult(input logic [ZONE_W-1:0] zone);
        logic [MULT_W-1:0] m;
        unique case (zone)
            3'd0, 3'd7: m = 16'd31458;  // reduction 4
            3'd1, 3'd6: m = 16'd36701;  // reduction 3
            3'd2, 3'd5: m = 16'd41944;  // reduction 2
            3'd3, 3'd4: m = 16'd47187;  // reduction 1
            default:    m = 16'd47187;
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/sdp_duty_calc.sv
// ----------------------------------------------------------------------------
// sdp_duty_calc
// Outer and inner wheel duties from throttle and steering angle.
// ----------------------------------------------------------------------------
module sdp_duty_calc
(
    input  logic [sdp_pkg::SAMPLE_W-1:0] throttle,
    input  logic [sdp_pkg::SAMPLE_W-1:0] angle,
    output sdp_pkg::duty_result_t        result
);

    logic [sdp_pkg::ZONE_W-1:0]   zone;
    logic [17:0]                  outer_prod;
    logic [25:0]                  inner_prod;
    logic [sdp_pkg::DUTY_W-1:0]   outer_duty;
    logic [sdp_pkg::DUTY_W-1:0]   inner_duty;

    assign zone       = angle[sdp_pkg::SAMPLE_W-1 -: sdp_pkg::ZONE_W];
    assign outer_prod = 18'(throttle) * 18'(sdp_pkg::OUTER_MULT);
    assign inner_prod = 26'(throttle) * 26'(sdp_pkg::inner_mult(zone));

    assign outer_duty = outer_prod[sdp_pkg::OUTER_SHIFT +: sdp_pkg::DUTY_W];
    assign inner_duty = inner_prod[sdp_pkg::INNER_SHIFT +: sdp_pkg::DUTY_W];

    // Steering right puts the right wheel on the inside of the turn
    always_comb
    begin
        result.steer_right = zone[sdp_pkg::ZONE_W-1];
        if (zone[sdp_pkg::ZONE_W-1])
        begin
            result.left_duty  = outer_duty;
            result.right_duty = inner_duty;
        end
        else
        begin
            result.left_duty  = inner_duty;
            result.right_duty = outer_duty;
        end
    end

endmodule

// File: rtl/core/steering_differential_pwm.sv
// ----------------------------------------------------------------------------
// steering_differential_pwm
// Electronic differential for two motors with counter-based PWM outputs.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload
//  --------  ---------  ------------------------------------------------------
//  s_*       in         tuser: func (0 tick, 1 sample); tdata[9:0]: adc_value
//  m_*       out        tdata: left_pwm, right_pwm, steer_led_off,
//                              left_duty[6:0], right_duty[6:0]
//  APB       in/out     pwm_period at byte address 0
//
//  One item per cycle sustained while m_tready stays high; each input beat
//  passes the input register, then the state registers that drive m_tdata.
//  The duty multiply by a per-zone constant sets the longest path.
//  Reset clears the PWM counter, both samples, both duties and all pins, and
//  sets the period to 100. A stalled result holds the state registers and
//  the input register; s_tready drops only when both are occupied.
//
module steering_differential_pwm
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] adc_value, [15:10] zero
    input  logic        s_tuser,   // [0] func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] left_pwm, [1] right_pwm, [2] steer_led_off,
                                   // [9:3] left_duty, [16:10] right_duty, [23:17] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned SW = sdp_pkg::SAMPLE_W;
    localparam int unsigned DW = sdp_pkg::DUTY_W;
    localparam int unsigned CW = sdp_pkg::COUNT_W;

    // Configuration
    logic [CW-1:0] period_reg;
    logic          cfg_write;

    // Input register
    logic          in_valid_reg;
    logic          in_func_reg;
    logic [SW-1:0] in_adc_reg;

    // Block state, which also forms the result register
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SW-1:0] throttle_reg;
    logic [SW-1:0] throttle_next;
    logic [SW-1:0] angle_reg;
    logic [SW-1:0] angle_next;
    logic          next_is_angle_reg;
    logic          next_is_angle_next;
    logic [DW-1:0] left_duty_reg;
    logic [DW-1:0] left_duty_next;
    logic [DW-1:0] right_duty_reg;
    logic [DW-1:0] right_duty_next;
    logic          left_pwm_reg;
    logic          left_pwm_next;
    logic          right_pwm_reg;
    logic          right_pwm_next;
    logic          led_reg;
    logic          led_next;

    logic          s_accept;
    logic          advance;
    logic [CW:0]   tick_count;
    logic [SW-1:0] calc_throttle;
    logic [SW-1:0] calc_angle;

    sdp_pkg::duty_result_t duty_result;

    // ------------------------------------------------------------------
    // APB register file: one register, writes on the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr == sdp_pkg::ADDR_PWM_PERIOD);

    always_comb
    begin
        if (paddr == sdp_pkg::ADDR_PWM_PERIOD)
            prdata = {{(32-CW){1'b0}}, period_reg};
        else
            prdata = 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= sdp_pkg::PERIOD_RESET;
        else if (cfg_write)
            period_reg <= pwdata[CW-1:0];
    end

    // ------------------------------------------------------------------
    // Handshake: the input register drains into the state whenever the
    // previous result is gone or is leaving this cycle
    // ------------------------------------------------------------------
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept || advance)
            in_valid_reg <= s_accept;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_func_reg <= s_tuser;
            in_adc_reg  <= s_tdata[SW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Duty recompute: the arriving sample replaces throttle or angle
    // ------------------------------------------------------------------
    assign calc_throttle = next_is_angle_reg ? throttle_reg : in_adc_reg;
    assign calc_angle    = next_is_angle_reg ? in_adc_reg   : angle_reg;

    sdp_duty_calc u_duty_calc
    (
        .throttle (calc_throttle),
        .angle    (calc_angle),
        .result   (duty_result)
    );

    // Tick: compare the incremented count, then wrap at or above the period
    assign tick_count = {1'b0, count_reg} + {{CW{1'b0}}, 1'b1};

    always_comb
    begin
        count_next         = count_reg;
        throttle_next      = throttle_reg;
        angle_next         = angle_reg;
        next_is_angle_next = next_is_angle_reg;
        left_duty_next     = left_duty_reg;
        right_duty_next    = right_duty_reg;
        left_pwm_next      = left_pwm_reg;
        right_pwm_next     = right_pwm_reg;
        led_next           = led_reg;

        if (advance)
        begin
            if (!in_func_reg)
            begin
                left_pwm_next  = tick_count < {1'b0, left_duty_reg};
                right_pwm_next = tick_count < {1'b0, right_duty_reg};
                if (tick_count >= {1'b0, period_reg})
                    count_next = '0;
                else
                    count_next = tick_count[CW-1:0];
            end
            else
            begin
                throttle_next      = calc_throttle;
                angle_next         = calc_angle;
                next_is_angle_next = !next_is_angle_reg;
                left_duty_next     = duty_result.left_duty;
                right_duty_next    = duty_result.right_duty;
                led_next           = duty_result.steer_right;
            end
        end
    end

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            count_reg         <= '0;
            throttle_reg      <= '0;
            angle_reg         <= '0;
            next_is_angle_reg <= 1'b0;
            left_duty_reg     <= '0;
            right_duty_reg    <= '0;
            left_pwm_reg      <= 1'b0;
            right_pwm_reg     <= 1'b0;
            led_reg           <= 1'b0;
        end
        else
        begin
            out_valid_reg     <= out_valid_next;
            count_reg         <= count_next;
            throttle_reg      <= throttle_next;
            angle_reg         <= angle_next;
            next_is_angle_reg <= next_is_angle_next;
            left_duty_reg     <= left_duty_next;
            right_duty_reg    <= right_duty_next;
            left_pwm_reg      <= left_pwm_next;
            right_pwm_reg     <= right_pwm_next;
            led_reg           <= led_next;
        end
    end

    // The state only moves on advance, and advance waits for the previous
    // beat to leave, so the state registers are the result beat itself
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, right_duty_reg, left_duty_reg,
                       led_reg, right_pwm_reg, left_pwm_reg};

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        (left_duty_reg <= 7'd102) && (right_duty_reg <= 7'd102))
        else $error("duty above 102");

    a_outer_ge_inner: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg ? (left_duty_reg >= right_duty_reg) : (right_duty_reg >= left_duty_reg))
        else $error("inner wheel duty exceeds outer wheel duty");

    a_sample_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_func_reg |=> next_is_angle_reg != $past(next_is_angle_reg))
        else $error("sample did not alternate throttle and angle");

    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_func_reg |=>
            (count_reg == '0) || (count_reg == $past(count_reg) + 7'd1))
        else $error("counter neither wrapped nor advanced by one");

    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg && $stable(in_adc_reg))
        else $error("input register dropped an item while stalled");
`endif

endmodule
